// File: rtl/core/cfes_pkg.sv
// ============================================================================
// Central force Euler step package
// Shared constants, codes, types and the saturating add used by the core.
// ============================================================================
package cfes_pkg;

   // Fraction bits of positions, velocities and the acceleration magnitude.
   localparam int FRAC_BITS = 16;
   // Fraction bits of the time step, fixed whatever FRAC_BITS is.
   localparam int DT_FRAC   = 16;
   // Numerator width of the unit vector division.
   localparam int DIV_W     = 32 + FRAC_BITS;
   // Width of the serial unit's main shift register.
   localparam int ACC_W     = 64;
   // Iteration counter width, enough for the longest operation.
   localparam int CNT_W     = $clog2(DIV_W + 1);

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_CENTRE_X = 2'd0;
   localparam logic [1:0] REG_CENTRE_Y = 2'd1;
   localparam logic [1:0] REG_ACCEL    = 2'd2;

   // Operation codes of the serial arithmetic unit.
   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SQX,
      S_SQY,
      S_ROOT,
      S_DIVX,
      S_ACCX,
      S_GX,
      S_DIVY,
      S_ACCY,
      S_GY,
      S_POSX,
      S_POSY,
      S_OUT
   } state_type;

   // Adds a signed magnitude to a 32-bit signed value and clamps to the
   // 32-bit signed range. Bit 32 of the result is the clip flag.
   function automatic logic [32:0] sat_add(input logic [31:0] base,
                                           input logic        neg,
                                           input logic [31:0] mag);
      logic [33:0] ext_mag;
      logic [33:0] sum;
      logic [32:0] res;
      ext_mag = {2'b00, mag};
      sum = {{2{base[31]}}, base} + (neg ? (34'd0 - ext_mag) : ext_mag);
      if (!sum[33] && (sum[32:31] != 2'b00)) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (sum[33] && (sum[32:31] != 2'b11)) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, sum[31:0]};
      end
      return res;
   endfunction

endpackage

// File: rtl/core/cfes_serial_unit.sv
// ============================================================================
// Serial arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root,
// one bit (two radicand bits for the root) per cycle over shared registers.
// ============================================================================
module cfes_serial_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  cfes_pkg::unit_ctl_type    ctl,
   input  logic [cfes_pkg::ACC_W-1:0] opnd_a,
   input  logic [31:0]               opnd_b,
   output logic [cfes_pkg::ACC_W-1:0] result,
   output cfes_pkg::unit_sts_type    sts
);

   logic [cfes_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [34:0]                rem_ff, rem_in;
   logic [31:0]                aux_ff, aux_in;
   logic [cfes_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   cfes_pkg::unit_op_type      op_ff, op_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [32:0] mul_sum;
   logic [32:0] div_rem;
   logic        div_ge;
   logic [34:0] sq_rem;
   logic [34:0] sq_trial;
   logic        sq_ge;

   always_comb begin
      mul_sum  = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, aux_ff} : 33'd0);
      div_rem  = {rem_ff[31:0], acc_ff[63]};
      div_ge   = (div_rem >= {1'b0, aux_ff});
      sq_rem   = {rem_ff[32:0], acc_ff[63:62]};
      sq_trial = {1'b0, aux_ff, 2'b01};
      sq_ge    = (sq_rem >= sq_trial);
   end

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      aux_in  = aux_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         op_in   = ctl.op;
         busy_in = 1'b1;
         rem_in  = '0;
         case (ctl.op)
            cfes_pkg::OP_MUL: begin
               acc_in = {32'd0, opnd_a[31:0]};
               aux_in = opnd_b;
               cnt_in = cfes_pkg::CNT_W'(32);
            end
            cfes_pkg::OP_DIV: begin
               acc_in = {opnd_a[cfes_pkg::DIV_W-1:0],
                         {(cfes_pkg::ACC_W - cfes_pkg::DIV_W){1'b0}}};
               aux_in = opnd_b;
               cnt_in = cfes_pkg::CNT_W'(cfes_pkg::DIV_W);
            end
            default: begin
               acc_in = opnd_a;
               aux_in = '0;
               cnt_in = cfes_pkg::CNT_W'(32);
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            cfes_pkg::OP_MUL: begin
               acc_in = {mul_sum, acc_ff[31:1]};
            end
            cfes_pkg::OP_DIV: begin
               rem_in = {2'b00, (div_ge ? (div_rem - {1'b0, aux_ff}) : div_rem)};
               acc_in = {acc_ff[62:0], div_ge};
            end
            default: begin
               rem_in = sq_ge ? (sq_rem - sq_trial) : sq_rem;
               aux_in = {aux_ff[30:0], sq_ge};
               acc_in = {acc_ff[61:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == cfes_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= cfes_pkg::OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      aux_ff <= aux_in;
   end

   assign result   = (op_ff == cfes_pkg::OP_SQRT) ? {32'd0, aux_ff} : acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// File: rtl/core/central_force_euler_step_top.sv
// ============================================================================
// Central force Euler step, top level
// One body moved by a constant-magnitude pull toward a fixed centre.
// ============================================================================
// The block keeps one body's position and velocity in signed Q16.16. A word
// with tuser high places the body and zeroes its velocity; its result word
// then passes through S_OUT into the output register, and the block goes
// back to S_IDLE as that register is loaded. A word with tuser low advances
// the body by the time step in its tdata: the unit vector toward the centre
// comes from a square root and two divisions, the velocity gains
// accel_magnitude times that vector times the step, and the position then
// gains the new velocity times the step. All of the arithmetic runs through
// one bit-serial unit, which works through eight multiplies, a root and two
// divides in turn, each launched and then waited on until done. The result
// then passes through S_OUT into the output register as well. When the body
// sits on the centre, only the two position multiplies run. Every accepted
// word yields exactly one result word. The block takes one word at a time; a
// finished result may wait in the output register while the next word is
// accepted and worked on, and a result that is still waiting there only
// holds back the end of the following word.
module central_force_euler_step_top (
   input  logic         clock,
   input  logic         reset,
   // Input words.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // place_x, place_y, step_time
   input  logic         req_tuser,   // command: 0 advance, 1 place
   // Result words.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // pos_x, pos_y, vel_x, vel_y
   output logic [1:0]   rsp_tuser,   // at_centre, saturated
   // Configuration writes.
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   // Configuration registers.
   logic [31:0] centre_x_ff, centre_y_ff, accel_ff;

   // Body state.
   logic [31:0] body_x_ff, body_x_in;
   logic [31:0] body_y_ff, body_y_in;
   logic [31:0] speed_x_ff, speed_x_in;
   logic [31:0] speed_y_ff, speed_y_in;

   // Working registers of one advance.
   cfes_pkg::state_type state_ff, state_in;
   logic        launched_ff, launched_in;
   logic [15:0] dt_ff, dt_in;
   logic        neg_x_ff, neg_x_in;
   logic        neg_y_ff, neg_y_in;
   logic [30:0] ax_ff, ax_in;
   logic [30:0] ay_ff, ay_in;
   logic [62:0] sum_ff, sum_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] work_ff, work_in;
   logic        at_c_ff, at_c_in;
   logic        sat_ff, sat_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;

   // Serial unit hookup.
   cfes_pkg::unit_ctl_type     u_ctl;
   cfes_pkg::unit_sts_type     u_sts;
   logic [cfes_pkg::ACC_W-1:0] u_a;
   logic [31:0]                u_b;
   logic [cfes_pkg::ACC_W-1:0] u_res;

   // Distance to the centre, worked out as a word is accepted.
   logic [32:0] dx, dy, mx, my;
   logic        big;
   logic        accept;

   // Velocity magnitudes and the scaled results of the unit.
   logic [31:0] mag_vx, mag_vy;
   logic [31:0] acc_scaled, dt_scaled;
   logic [32:0] sat_res;

   cfes_serial_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (u_ctl),
      .opnd_a (u_a),
      .opnd_b (u_b),
      .result (u_res),
      .sts    (u_sts)
   );

   assign accept = req_tvalid && req_tready;

   always_comb begin
      dx  = {centre_x_ff[31], centre_x_ff} - {body_x_ff[31], body_x_ff};
      dy  = {centre_y_ff[31], centre_y_ff} - {body_y_ff[31], body_y_ff};
      mx  = dx[32] ? (33'd0 - dx) : dx;
      my  = dy[32] ? (33'd0 - dy) : dy;
      // Halve both when either is too large, so the squares fit 63 bits.
      big = mx[32] | mx[31] | my[32] | my[31];
      mag_vx = speed_x_ff[31] ? (32'd0 - speed_x_ff) : speed_x_ff;
      mag_vy = speed_y_ff[31] ? (32'd0 - speed_y_ff) : speed_y_ff;
      acc_scaled = u_res[cfes_pkg::FRAC_BITS +: 32];
      dt_scaled  = u_res[cfes_pkg::DT_FRAC +: 32];
   end

   // Configuration writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         accel_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            cfes_pkg::REG_CENTRE_X: centre_x_ff <= csr_wdata;
            cfes_pkg::REG_CENTRE_Y: centre_y_ff <= csr_wdata;
            cfes_pkg::REG_ACCEL:    accel_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: each arithmetic state launches the serial unit once and
   // moves on when the unit reports done, folding its result into state.
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      dt_in        = dt_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      work_in      = work_ff;
      at_c_in      = at_c_ff;
      sat_in       = sat_ff;
      body_x_in    = body_x_ff;
      body_y_in    = body_y_ff;
      speed_x_in   = speed_x_ff;
      speed_y_in   = speed_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      u_ctl.start  = 1'b0;
      u_ctl.op     = cfes_pkg::OP_MUL;
      u_a          = '0;
      u_b          = '0;
      sat_res      = '0;

      // Operand selection for the serial unit.
      case (state_ff)
         cfes_pkg::S_SQX: begin
            u_a = {33'd0, ax_ff};
            u_b = {1'b0, ax_ff};
         end
         cfes_pkg::S_SQY: begin
            u_a = {33'd0, ay_ff};
            u_b = {1'b0, ay_ff};
         end
         cfes_pkg::S_ROOT: begin
            u_ctl.op = cfes_pkg::OP_SQRT;
            u_a      = {1'b0, sum_ff};
         end
         cfes_pkg::S_DIVX: begin
            u_ctl.op = cfes_pkg::OP_DIV;
            u_a      = cfes_pkg::ACC_W'({ax_ff, {cfes_pkg::FRAC_BITS{1'b0}}});
            u_b      = root_ff;
         end
         cfes_pkg::S_DIVY: begin
            u_ctl.op = cfes_pkg::OP_DIV;
            u_a      = cfes_pkg::ACC_W'({ay_ff, {cfes_pkg::FRAC_BITS{1'b0}}});
            u_b      = root_ff;
         end
         cfes_pkg::S_ACCX, cfes_pkg::S_ACCY: begin
            u_a = {32'd0, work_ff};
            u_b = accel_ff;
         end
         cfes_pkg::S_GX, cfes_pkg::S_GY: begin
            u_a = {48'd0, dt_ff};
            u_b = work_ff;
         end
         cfes_pkg::S_POSX: begin
            u_a = {48'd0, dt_ff};
            u_b = mag_vx;
         end
         cfes_pkg::S_POSY: begin
            u_a = {48'd0, dt_ff};
            u_b = mag_vy;
         end
         default: ;
      endcase

      case (state_ff)
         cfes_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               at_c_in = 1'b0;
               sat_in  = 1'b0;
               if (req_tuser) begin
                  body_x_in  = req_tdata[31:0];
                  body_y_in  = req_tdata[63:32];
                  speed_x_in = '0;
                  speed_y_in = '0;
                  state_in   = cfes_pkg::S_OUT;
               end else begin
                  dt_in    = req_tdata[79:64];
                  neg_x_in = dx[32];
                  neg_y_in = dy[32];
                  ax_in    = big ? mx[31:1] : mx[30:0];
                  ay_in    = big ? my[31:1] : my[30:0];
                  if ((mx == 33'd0) && (my == 33'd0)) begin
                     at_c_in  = 1'b1;
                     state_in = cfes_pkg::S_POSX;
                  end else begin
                     state_in = cfes_pkg::S_SQX;
                  end
               end
            end
         end
         cfes_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {speed_y_ff, speed_x_ff, body_y_ff, body_x_ff};
               rsp_user_in  = {sat_ff, at_c_ff};
               state_in     = cfes_pkg::S_IDLE;
            end
         end
         default: begin
            if (!launched_ff) begin
               u_ctl.start = 1'b1;
               launched_in = 1'b1;
            end else if (u_sts.done) begin
               launched_in = 1'b0;
               case (state_ff)
                  cfes_pkg::S_SQX: begin
                     sum_in   = u_res[62:0];
                     state_in = cfes_pkg::S_SQY;
                  end
                  cfes_pkg::S_SQY: begin
                     sum_in   = sum_ff + u_res[62:0];
                     state_in = cfes_pkg::S_ROOT;
                  end
                  cfes_pkg::S_ROOT: begin
                     root_in  = u_res[31:0];
                     state_in = cfes_pkg::S_DIVX;
                  end
                  cfes_pkg::S_DIVX: begin
                     work_in  = u_res[31:0];
                     state_in = cfes_pkg::S_ACCX;
                  end
                  cfes_pkg::S_ACCX: begin
                     work_in  = acc_scaled;
                     state_in = cfes_pkg::S_GX;
                  end
                  cfes_pkg::S_GX: begin
                     sat_res    = cfes_pkg::sat_add(speed_x_ff, neg_x_ff, dt_scaled);
                     speed_x_in = sat_res[31:0];
                     sat_in     = sat_ff | sat_res[32];
                     state_in   = cfes_pkg::S_DIVY;
                  end
                  cfes_pkg::S_DIVY: begin
                     work_in  = u_res[31:0];
                     state_in = cfes_pkg::S_ACCY;
                  end
                  cfes_pkg::S_ACCY: begin
                     work_in  = acc_scaled;
                     state_in = cfes_pkg::S_GY;
                  end
                  cfes_pkg::S_GY: begin
                     sat_res    = cfes_pkg::sat_add(speed_y_ff, neg_y_ff, dt_scaled);
                     speed_y_in = sat_res[31:0];
                     sat_in     = sat_ff | sat_res[32];
                     state_in   = cfes_pkg::S_POSX;
                  end
                  cfes_pkg::S_POSX: begin
                     sat_res   = cfes_pkg::sat_add(body_x_ff, speed_x_ff[31], dt_scaled);
                     body_x_in = sat_res[31:0];
                     sat_in    = sat_ff | sat_res[32];
                     state_in  = cfes_pkg::S_POSY;
                  end
                  default: begin
                     sat_res   = cfes_pkg::sat_add(body_y_ff, speed_y_ff[31], dt_scaled);
                     body_y_in = sat_res[31:0];
                     sat_in    = sat_ff | sat_res[32];
                     state_in  = cfes_pkg::S_OUT;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfes_pkg::S_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         body_x_ff    <= '0;
         body_y_ff    <= '0;
         speed_x_ff   <= '0;
         speed_y_ff   <= '0;
         at_c_ff      <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         body_x_ff    <= body_x_in;
         body_y_ff    <= body_y_in;
         speed_x_ff   <= speed_x_in;
         speed_y_ff   <= speed_y_in;
         at_c_ff      <= at_c_in;
         sat_ff       <= sat_in;
      end
      dt_ff       <= dt_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      sum_ff      <= sum_in;
      root_ff     <= root_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/core/cfes_checker.sv
// ============================================================================
// Central force Euler step checker
// Port-level properties of the top level, bound to it below.
// ============================================================================
module cfes_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // Out of reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // One word at a time: an accepted word closes the input for a while.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input open right after an accepted word");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // A result on offer carries fully known data and flags.
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tuser}))
      else $error("result carries unknown bits");

endmodule

bind central_force_euler_step_top cfes_checker u_cfes_checker (.*);
